// ----- rtl/mpt_pkg.sv -----
package mpt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_W         = 13;
    localparam int BTN_W          = 5;
    localparam int WHEEL_W        = 4;
    localparam int DELTA_W        = 9;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(600);

    // byte 0 layout
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;

    // byte 3 layout
    localparam int BTN45_LSB = 4;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    typedef enum logic
    {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

// ----- rtl/mpt_byte_stage.sv -----
module mpt_byte_stage
    import mpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       stage_valid,
    input  logic       stage_ready,
    output logic [7:0] stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready    = !valid_reg || stage_ready;
    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (stage_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the beat until the core takes it
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

// ----- rtl/mpt_packet_core.sv -----
module mpt_packet_core
    import mpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  stage_valid,
    output logic                  stage_ready,
    input  logic [7:0]            stage_byte,
    input  logic [SIZE_W-1:0]     width,
    input  logic [SIZE_W-1:0]     height,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pos_x,
    output logic [COORD_BITS-1:0] pos_y,
    output logic [BTN_W-1:0]      button_state,
    output logic [BTN_W-1:0]      button_changes,
    output logic signed [WHEEL_W-1:0] wheel_steps,
    output logic                  moved
);

    localparam int WIDE = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

    logic [1:0]            slot_reg;
    logic [1:0]            slot_next;
    logic [7:0]            held_reg [3];
    logic [COORD_BITS-1:0] ptr_x_reg;
    logic [COORD_BITS-1:0] ptr_x_next;
    logic [COORD_BITS-1:0] ptr_y_reg;
    logic [COORD_BITS-1:0] ptr_y_next;
    logic [BTN_W-1:0]      last_btn_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  take;
    logic                  last_beat;
    logic [DELTA_W-1:0]    dx;
    logic [DELTA_W-1:0]    dy;
    logic                  any_move;
    logic [BTN_W-1:0]      buttons;
    logic signed [WIDE-1:0] sum_x;
    logic signed [WIDE-1:0] sum_y;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [WIDE-1:0] v,
        input logic [SIZE_W-1:0]      size
    );
        logic [SIZE_W-1:0]      lim_raw;
        logic signed [WIDE-1:0] lim;
        logic signed [WIDE-1:0] cmax;
        logic signed [WIDE-1:0] res;
        lim_raw = (size == '0) ? '0 : size - SIZE_W'(1);
        lim     = $signed({{(WIDE-SIZE_W){1'b0}}, lim_raw});
        cmax    = $signed({{(WIDE-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});
        if (lim > cmax)
        begin
            lim = cmax;
        end
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > lim)
        begin
            res = lim;
        end
        else
        begin
            res = v;
        end
        return res[COORD_BITS-1:0];
    endfunction

    assign last_beat   = (slot_reg == LAST_SLOT);
    // a result slot is only needed on the closing beat of a packet
    assign stage_ready = !last_beat || !out_valid_reg || out_ready;
    assign take        = stage_valid && stage_ready;

    assign dx       = {held_reg[0][X_SIGN_BIT], held_reg[1]};
    assign dy       = {held_reg[0][Y_SIGN_BIT], held_reg[2]};
    assign any_move = (dx != '0) || (dy != '0);
    assign buttons  = {stage_byte[BTN45_LSB+1:BTN45_LSB], held_reg[0][2:0]};

    assign sum_x = $signed({{(WIDE-COORD_BITS){1'b0}}, ptr_x_reg})
                 + $signed({{(WIDE-DELTA_W){dx[DELTA_W-1]}}, dx});
    assign sum_y = $signed({{(WIDE-COORD_BITS){1'b0}}, ptr_y_reg})
                 - $signed({{(WIDE-DELTA_W){dy[DELTA_W-1]}}, dy});

    always_comb
    begin
        slot_next      = slot_reg;
        ptr_x_next     = ptr_x_reg;
        ptr_y_next     = ptr_y_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take)
        begin
            if (last_beat)
            begin
                slot_next      = '0;
                out_valid_next = 1'b1;
                // no movement leaves the pointer unclamped
                if (any_move)
                begin
                    ptr_x_next = clamp_axis(sum_x, width);
                    ptr_y_next = clamp_axis(sum_y, height);
                end
            end
            else
            begin
                slot_next = slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            ptr_x_reg     <= '0;
            ptr_y_reg     <= '0;
            last_btn_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            ptr_x_reg     <= ptr_x_next;
            ptr_y_reg     <= ptr_y_next;
            out_valid_reg <= out_valid_next;
            if (take && last_beat)
            begin
                last_btn_reg <= buttons;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !last_beat)
        begin
            held_reg[slot_reg] <= stage_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last_beat)
        begin
            pos_x          <= ptr_x_next;
            pos_y          <= ptr_y_next;
            button_state   <= buttons;
            button_changes <= buttons ^ last_btn_reg;
            wheel_steps    <= $signed(stage_byte[WHEEL_W-1:0]);
            moved          <= any_move;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/mouse_packet_pointer_tracker.sv -----
// Result: the fourth byte of a packet passes the input register, then the core registers the result.
// Throughput: one byte per cycle; the input register and the result register let the
//   pointer update run every cycle. A stalled result holds back only a closing byte,
//   which then sits in the input register and stalls the input.
// Reset (rst_n, asynchronous, active low): packet position, pointer and buttons clear
//   to zero, screen size returns to 800 by 600, no result is pending.
module mouse_packet_pointer_tracker
    import mpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pos_x,
    output logic [COORD_BITS-1:0] pos_y,
    output logic [BTN_W-1:0]      button_state,
    output logic [BTN_W-1:0]      button_changes,
    output logic signed [WHEEL_W-1:0] wheel_steps,
    output logic                  moved
);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              stage_valid;
    logic              stage_ready;
    logic [7:0]        stage_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    mpt_byte_stage u_byte_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_byte  (stage_byte)
    );

    mpt_packet_core #(
        .COORD_BITS (COORD_BITS)
    ) u_packet_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage_valid    (stage_valid),
        .stage_ready    (stage_ready),
        .stage_byte     (stage_byte),
        .width          (width_reg),
        .height         (height_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .button_state   (button_state),
        .button_changes (button_changes),
        .wheel_steps    (wheel_steps),
        .moved          (moved)
    );

`ifndef ASSERT_OFF
    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stage_valid)
        else $error("input stage stalls while empty");

    a_result_from_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stage_valid && stage_ready))
        else $error("result appeared without a beat taken from the input stage");

    a_stalled_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !stage_ready |=> stage_valid && $stable(stage_byte))
        else $error("stalled beat lost from the input stage");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mpt_pkg::*;

    localparam int CB                = COORD_BITS_DEF;
    localparam int COORD_TOP         = (1 << CB) - 1;
    localparam int PHASES            = 9;
    localparam int PACKETS_PER_PHASE = 29;
    localparam int HOLD_CYCLES       = 300;
    localparam int SETTLE_CYCLES     = 6;

    typedef struct packed {
        logic [CB-1:0]             x;
        logic [CB-1:0]             y;
        logic [BTN_W-1:0]          btn;
        logic [BTN_W-1:0]          chg;
        logic signed [WHEEL_W-1:0] wheel;
        logic                      mv;
    } report_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        report_t    r;
    } script_row_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic                  cfg_index  = CFG_WIDTH;
    logic [SIZE_W-1:0]     cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic [7:0]            data_byte  = '0;
    logic                  out_ready  = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [CB-1:0]         pos_x;
    logic [CB-1:0]         pos_y;
    logic [BTN_W-1:0]      button_state;
    logic [BTN_W-1:0]      button_changes;
    logic signed [WHEEL_W-1:0] wheel_steps;
    logic                  moved;

    // decoder state as the block should hold it
    int         pkt_pos = 0;
    logic [7:0] held [3] = '{8'h00, 8'h00, 8'h00};
    int         ptr_x = 0;
    int         ptr_y = 0;
    logic [4:0] prev_btn = '0;
    int         scr_w = WIDTH_RESET;
    int         scr_h = HEIGHT_RESET;

    report_t pending_reports [$];
    int      mismatches = 0;
    int      n_reports  = 0;
    int      n_at_rest  = 0;
    int      n_bytes    = 0;
    int      tx_idle_pct = 17;
    int      rx_idle_pct = 80;
    bit      hold_req    = 1'b0;

    // opening packets under the reset screen size
    script_row_t script [24] = '{
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{12'd0, 12'd0, 5'h00, 5'h00, 4'sd0, 1'b0}},
        '{8'h27, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h37, 1'b1, '{12'd255, 12'd256, 5'h1F, 5'h1F, 4'sd7, 1'b1}},
        '{8'h30, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h08, 1'b1, '{12'd0, 12'd512, 5'h00, 5'h1F, -4'sd8, 1'b1}},
        '{8'h20, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h2A, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'hF0, 1'b0, '0}
    };

    mouse_packet_pointer_tracker #(
        .COORD_BITS(CB)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .button_state   (button_state),
        .button_changes (button_changes),
        .wheel_steps    (wheel_steps),
        .moved          (moved)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int clamp_coord(input int v, input int size);
        int lim;
        lim = (size == 0) ? 0 : size - 1;
        if (lim > COORD_TOP)
            lim = COORD_TOP;
        if (v < 0)
            return 0;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output report_t r);
        int         dx;
        int         dy;
        logic [4:0] btn;
        r = '0;
        if (pkt_pos < 3)
        begin
            held[pkt_pos] = b;
            pkt_pos++;
            return 1'b0;
        end
        pkt_pos = 0;
        dx = int'(held[1]) - (held[0][X_SIGN_BIT] ? 256 : 0);
        dy = int'(held[2]) - (held[0][Y_SIGN_BIT] ? 256 : 0);
        r.mv = (dx != 0) || (dy != 0);
        // a still packet leaves the pointer alone, even outside a shrunk screen
        if (r.mv)
        begin
            ptr_x = clamp_coord(ptr_x + dx, scr_w);
            ptr_y = clamp_coord(ptr_y - dy, scr_h);
        end
        btn      = {b[BTN45_LSB +: 2], held[0][2:0]};
        r.x      = ptr_x[CB-1:0];
        r.y      = ptr_y[CB-1:0];
        r.btn    = btn;
        r.chg    = btn ^ prev_btn;
        r.wheel  = b[3:0];
        prev_btn = btn;
        return 1'b1;
    endfunction

    // append at the tail of the expected-report queue
    function automatic void queue_report(input report_t r);
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit typed, input report_t typed_r);
        report_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_bytes++;
        if (decode_byte(b, r))
            queue_report(typed ? typed_r : r);
    endtask

    function automatic int pick_delta(input int lean);
        int k;
        k = $urandom_range(9);
        if (k < 2)
            return 0;
        if (lean != 0 && k < 5)
            return (lean > 0) ? 255 : -256;
        if (lean != 0 && k < 8)
            return (lean > 0) ? int'($urandom_range(255)) : -int'($urandom_range(256));
        if (k < 4)
            return $urandom_range(1) ? 255 : -256;
        return int'($urandom_range(511)) - 256;
    endfunction

    task automatic send_packet(input bit still, input int lean);
        logic [8:0] dx9;
        logic [8:0] dy9;
        logic [7:0] b0;
        dx9 = still ? 9'd0 : 9'(pick_delta(lean));
        dy9 = still ? 9'd0 : 9'(pick_delta(-lean));
        b0  = 8'($urandom);
        b0[X_SIGN_BIT] = dx9[8];
        b0[Y_SIGN_BIT] = dy9[8];
        push_byte(b0, 1'b0, '0);
        push_byte(dx9[7:0], 1'b0, '0);
        push_byte(dy9[7:0], 1'b0, '0);
        push_byte(8'($urandom), 1'b0, '0);
    endtask

    task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        scr_w  = w;
        scr_h  = h;
    endtask

    task automatic drain_reports();
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        report_t want;
        report_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{pos_x, pos_y, button_state, button_changes, wheel_steps, moved};
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report beat expected none, got pos=(%0d,%0d)", $time,
                         pos_x, pos_y);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                n_reports++;
                if (!seen.mv)
                    n_at_rest++;
                if (seen !== want)
                begin
                    mismatches++;
                    if (seen.x !== want.x)
                        $display("%0t: pos_x expected %0d, got %0d", $time, want.x, seen.x);
                    if (seen.y !== want.y)
                        $display("%0t: pos_y expected %0d, got %0d", $time, want.y, seen.y);
                    if (seen.btn !== want.btn)
                        $display("%0t: button_state expected %h, got %h", $time, want.btn,
                                 seen.btn);
                    if (seen.chg !== want.chg)
                        $display("%0t: button_changes expected %h, got %h", $time, want.chg,
                                 seen.chg);
                    if (seen.wheel !== want.wheel)
                        $display("%0t: wheel_steps expected %0d, got %0d", $time, want.wheel,
                                 seen.wheel);
                    if (seen.mv !== want.mv)
                        $display("%0t: moved expected %b, got %b", $time, want.mv, seen.mv);
                end
            end
        end
    end

    initial
    begin
        int lean;
        int w;
        int h;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            push_byte(script[i].b, script[i].typed, script[i].r);
        in_valid <= 1'b0;
        drain_reports();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 3)
            begin
                tx_idle_pct = 80;
                rx_idle_pct = 17;
            end
            if (p == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0:
                begin
                    w = 4096;
                    h = 4096;
                end
                1:
                begin
                    w = 8191;
                    h = 4095;
                end
                2:
                begin
                    w = 1;
                    h = 1;
                end
                3:
                begin
                    w = 0;
                    h = 0;
                end
                4:
                begin
                    w = 5000;
                    h = 2;
                end
                5:
                begin
                    w = $urandom_range(4096, 1);
                    h = $urandom_range(4096, 1);
                end
                6:
                begin
                    w = 640;
                    h = 480;
                end
                7:
                begin
                    w = $urandom_range(8191);
                    h = $urandom_range(8191);
                end
                default:
                begin
                    w = 800;
                    h = 600;
                end
            endcase
            set_screen(w, h);
            // push towards the far corner on the big screens to reach the coordinate cap
            lean = (p < 2) ? 1 : int'($urandom_range(2)) - 1;
            if (p == 6)
                hold_req = 1'b1;
            for (int k = 0; k < PACKETS_PER_PHASE; k++)
                send_packet(k == 0 || $urandom_range(9) == 0, lean);
            in_valid <= 1'b0;
            drain_reports();
        end

        $display("Sent %0d bytes; checked %0d reports over %0d screen sizes, %0d at rest.",
                 n_bytes, n_reports, PHASES + 1, n_at_rest);
        $display("Included zero, one, oversize and capped sizes and a long result stall.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
